>>> sv/lspf_pkg.sv
// shared types and constants for the literal substring position finder
package lspf_pkg;

  localparam int QUERY_MAX = 16;
  localparam int CAND_MAX  = 1024;

  localparam int QLEN_W = $clog2(QUERY_MAX + 1);
  localparam int IDX_W  = $clog2(CAND_MAX + 1);
  localparam int SUM_W  = IDX_W + 1;
  localparam int POS_W  = 10;
  localparam int CH_W   = 8;

  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_SCAN      = 1'b1;
  localparam logic KIND_POS     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic            op;
    logic [CH_W-1:0] ch;
    logic            last;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] position;
    logic             found;
    logic             final_res;
  } out_item_t;

  // result burst handed from the match unit to the emitter
  typedef struct packed {
    logic              vld;
    logic [POS_W-1:0]  start;
    logic [QLEN_W-1:0] cnt;
    logic              verdict;
    logic              found;
  } burst_t;

endpackage

>>> sv/lspf_match.sv
// query store, candidate window and parallel window compare
module lspf_match (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  lspf_pkg::in_item_t  item,
  output lspf_pkg::burst_t    burst
);

  logic [lspf_pkg::QLEN_W-1:0] qlen_r, qlen_nxt, qlen_eff;
  logic                        qclosed_r, qclosed_nxt;
  logic [lspf_pkg::CH_W-1:0]   qrev_r [lspf_pkg::QUERY_MAX];
  logic [lspf_pkg::CH_W-1:0]   win_r  [lspf_pkg::QUERY_MAX];
  logic [lspf_pkg::CH_W-1:0]   win_nxt [lspf_pkg::QUERY_MAX];
  logic [lspf_pkg::IDX_W-1:0]  cidx_r, cidx_nxt;
  logic [lspf_pkg::IDX_W-1:0]  estart_r, estart_nxt;
  logic                        anym_r, anym_nxt;
  logic                        q_room, in_rng, hit, eq_all;
  logic [lspf_pkg::SUM_W-1:0]  end_cnt, need;
  logic [lspf_pkg::SUM_W-1:0]  start_full;
  logic [lspf_pkg::QUERY_MAX-1:0] eq;

  // query length bookkeeping: a load after close starts a fresh query
  assign qlen_eff = qclosed_r ? '0 : qlen_r;
  assign q_room   = qlen_eff < lspf_pkg::QLEN_W'(lspf_pkg::QUERY_MAX);
  assign in_rng   = cidx_r < lspf_pkg::IDX_W'(lspf_pkg::CAND_MAX);

  // shifted window with the new byte at the front
  always_comb begin
    win_nxt[0] = item.ch;
    for (int k = 1; k < lspf_pkg::QUERY_MAX; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  // per-position compare, query kept newest first so entry k pairs with window k
  always_comb begin
    for (int k = 0; k < lspf_pkg::QUERY_MAX; k++) begin
      eq[k] = (lspf_pkg::QLEN_W'(k) >= qlen_r) || (win_nxt[k] == qrev_r[k]);
    end
  end

  assign eq_all     = &eq;
  assign end_cnt    = lspf_pkg::SUM_W'(cidx_r) + lspf_pkg::SUM_W'(1);
  assign need       = lspf_pkg::SUM_W'(qlen_r) + lspf_pkg::SUM_W'(estart_r);
  assign hit        = (item.op == lspf_pkg::OP_SCAN) && in_rng && (qlen_r != '0) &&
                      (end_cnt >= need) && eq_all;
  assign start_full = end_cnt - lspf_pkg::SUM_W'(qlen_r);

  // burst description for the emitter
  always_comb begin
    burst.vld     = (item.op == lspf_pkg::OP_SCAN) && (hit || item.last);
    burst.start   = start_full[lspf_pkg::POS_W-1:0];
    burst.cnt     = hit ? qlen_r : '0;
    burst.verdict = item.last;
    burst.found   = anym_r || hit;
  end

  // next state of the control registers
  always_comb begin
    qlen_nxt    = qlen_r;
    qclosed_nxt = qclosed_r;
    cidx_nxt    = cidx_r;
    estart_nxt  = estart_r;
    anym_nxt    = anym_r;
    if (item.op == lspf_pkg::OP_LOAD) begin
      qlen_nxt    = q_room ? qlen_eff + lspf_pkg::QLEN_W'(1) : qlen_eff;
      qclosed_nxt = item.last;
    end else begin
      if (in_rng) begin
        cidx_nxt = end_cnt[lspf_pkg::IDX_W-1:0];
      end
      if (hit) begin
        estart_nxt = end_cnt[lspf_pkg::IDX_W-1:0];
        anym_nxt   = 1'b1;
      end
      if (item.last) begin
        cidx_nxt   = '0;
        estart_nxt = '0;
        anym_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r    <= '0;
      qclosed_r <= 1'b0;
      cidx_r    <= '0;
      estart_r  <= '0;
      anym_r    <= 1'b0;
    end else if (acc) begin
      qlen_r    <= qlen_nxt;
      qclosed_r <= qclosed_nxt;
      cidx_r    <= cidx_nxt;
      estart_r  <= estart_nxt;
      anym_r    <= anym_nxt;
    end
  end

  // query and window byte stores
  always_ff @(posedge clk) begin
    if (acc && (item.op == lspf_pkg::OP_LOAD) && q_room) begin
      qrev_r[0] <= item.ch;
      for (int k = 1; k < lspf_pkg::QUERY_MAX; k++) begin
        qrev_r[k] <= qrev_r[k-1];
      end
    end
    if (acc && (item.op == lspf_pkg::OP_SCAN) && in_rng) begin
      for (int k = 0; k < lspf_pkg::QUERY_MAX; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

endmodule

>>> sv/lspf_emit.sv
// result register that plays out a burst of positions and a verdict
module lspf_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  lspf_pkg::burst_t     burst,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lspf_pkg::out_item_t  out_data
);

  logic                        busy_r, busy_nxt;
  logic [lspf_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [lspf_pkg::QLEN_W-1:0] rem_r, rem_nxt;
  logic                        vrd_r, vrd_nxt;
  logic                        fnd_r, fnd_nxt;
  logic                        xfer, is_final;

  // current result
  assign is_final = (rem_r == '0) || ((rem_r == lspf_pkg::QLEN_W'(1)) && !vrd_r);
  always_comb begin
    if (rem_r != '0) begin
      out_data.kind     = lspf_pkg::KIND_POS;
      out_data.position = pos_r;
      out_data.found    = 1'b0;
    end else begin
      out_data.kind     = lspf_pkg::KIND_VERDICT;
      out_data.position = '0;
      out_data.found    = fnd_r;
    end
    out_data.final_res = is_final;
  end

  assign out_valid = busy_r;
  assign xfer      = busy_r && !out_stall;
  assign free      = !busy_r || (xfer && is_final);

  // advance through the burst, reload when a new one arrives
  always_comb begin
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    rem_nxt  = rem_r;
    vrd_nxt  = vrd_r;
    fnd_nxt  = fnd_r;
    if (xfer) begin
      if (is_final) begin
        busy_nxt = 1'b0;
      end
      if (rem_r != '0) begin
        rem_nxt = rem_r - lspf_pkg::QLEN_W'(1);
        pos_nxt = pos_r + lspf_pkg::POS_W'(1);
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      pos_nxt  = burst.start;
      rem_nxt  = burst.cnt;
      vrd_nxt  = burst.verdict;
      fnd_nxt  = burst.found;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    rem_r <= rem_nxt;
    vrd_r <= vrd_nxt;
    fnd_r <= fnd_nxt;
  end

endmodule

>>> sv/literal_substring_position_finder_top.sv
// the first result of a transaction is valid in the cycle after acceptance
// throughput: one transaction per cycle while out_stall is low and each causes
// at most one result; one causing more holds the output register and stalls
// the input until its last is taken; bursts are at most query length plus one
// reset: synchronous active-low; clears query length, candidate counters and
// the output valid; query and window bytes are not cleared
module literal_substring_position_finder_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lspf_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lspf_pkg::out_item_t  out_data
);

  logic             acc;
  logic             free;
  lspf_pkg::burst_t burst;

  assign in_stall = !free;
  assign acc      = in_valid && free;

  // match unit
  lspf_match u_match (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .item  (in_data),
    .burst (burst)
  );

  // output sequencer
  lspf_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (acc && burst.vld),
    .burst     (burst),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // input waits while a burst still has results after the current one
  a_stall_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.final_res |-> in_stall)
    else $error("input accepted in the middle of a burst");

  // a verdict always closes its transaction
  a_verdict_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == lspf_pkg::KIND_VERDICT) |-> out_data.final_res)
    else $error("verdict not marked final");

  // positions inside a burst step by one
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.final_res &&
    (out_data.kind == lspf_pkg::KIND_POS)
    |=> out_valid && ((out_data.kind == lspf_pkg::KIND_VERDICT) ||
        (out_data.position == $past(out_data.position) + lspf_pkg::POS_W'(1))))
    else $error("position burst broken");

  // a position result never carries a found flag
  a_pos_no_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == lspf_pkg::KIND_POS) |-> !out_data.found)
    else $error("found flag on a position result");

endmodule
